// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte transfer engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd255;
    localparam logic [7:0] RECV_LAST_TICK  = 8'd16;
    localparam logic [7:0] READ_DIR_BIT    = 8'h01;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_W_START    = 5'd1,
        PH_W_DEV      = 5'd2,
        PH_W_DEV_ACK  = 5'd3,
        PH_W_REG      = 5'd4,
        PH_W_REG_ACK  = 5'd5,
        PH_W_DATA     = 5'd6,
        PH_W_DATA_ACK = 5'd7,
        PH_STOP       = 5'd8,
        PH_R_START1   = 5'd9,
        PH_R_DEV      = 5'd10,
        PH_R_DEV_ACK  = 5'd11,
        PH_R_REG      = 5'd12,
        PH_R_REG_ACK  = 5'd13,
        PH_R_START2   = 5'd14,
        PH_R_DEVR     = 5'd15,
        PH_R_DEVR_ACK = 5'd16,
        PH_R_RECV     = 5'd17,
        PH_R_NACK     = 5'd18
    } t_phase;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       use_reg_addr;
        logic       is_read;
    } t_request;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [3:0] attempt_count;
        logic [7:0] wait_cnt;
        logic       ack_all;
        t_request   req;
        logic       scl;
        logic       sda;
        logic       drive;
    } t_eng_state;

    typedef struct packed {
        logic [3:0] retry_limit;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_data;
    } t_result;

    localparam t_eng_state ENG_STATE_RST = '{
        phase:         PH_IDLE,
        bit_count:     3'd0,
        shift_byte:    8'd0,
        attempt_count: 4'd0,
        wait_cnt:      8'd0,
        ack_all:       1'b1,
        req:           '0,
        scl:           1'b1,
        sda:           1'b1,
        drive:         1'b1
    };

endpackage

// ===== design/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one bus tick of the I2C master engine.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::t_eng_state i_state,
    input  i2cm_pkg::t_cfg       i_cfg,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_dev_addr,
    input  logic [7:0]           i_reg_addr,
    input  logic                 i_use_reg_addr,
    input  logic [7:0]           i_write_data,
    input  logic                 i_sda_in,
    output i2cm_pkg::t_eng_state o_state,
    output i2cm_pkg::t_result    o_result
);

    function automatic i2cm_pkg::t_eng_state f_enter(i2cm_pkg::t_eng_state s,
                                                     i2cm_pkg::t_phase p);
        i2cm_pkg::t_eng_state r;
        r           = s;
        r.phase     = p;
        r.bit_count = 3'd0;
        r.wait_cnt  = 8'd0;
        unique case (p)
            i2cm_pkg::PH_W_DEV,
            i2cm_pkg::PH_R_DEV:  r.shift_byte = s.req.dev_addr;
            i2cm_pkg::PH_W_REG,
            i2cm_pkg::PH_R_REG:  r.shift_byte = s.req.reg_addr;
            i2cm_pkg::PH_W_DATA: r.shift_byte = s.req.write_data;
            i2cm_pkg::PH_R_DEVR: r.shift_byte = s.req.dev_addr | i2cm_pkg::READ_DIR_BIT;
            i2cm_pkg::PH_R_RECV: r.shift_byte = 8'd0;
            default:             r.shift_byte = s.shift_byte;
        endcase
        return r;
    endfunction

    function automatic i2cm_pkg::t_eng_state f_begin(i2cm_pkg::t_eng_state s);
        i2cm_pkg::t_eng_state r;
        r         = s;
        r.ack_all = 1'b1;
        if (!s.req.is_read) begin
            r = f_enter(r, i2cm_pkg::PH_W_START);
        end else if (s.req.use_reg_addr) begin
            r = f_enter(r, i2cm_pkg::PH_R_START1);
        end else begin
            r = f_enter(r, i2cm_pkg::PH_R_START2);
        end
        return r;
    endfunction

    always_comb begin
        i2cm_pkg::t_eng_state s;
        logic       fin;
        logic       done;
        logic       ok;
        logic [7:0] rd;
        logic [3:0] att;

        s    = i_state;
        fin  = 1'b0;
        done = 1'b0;
        ok   = 1'b0;
        rd   = 8'd0;
        att  = 4'd0;

        if (s.phase == i2cm_pkg::PH_IDLE) begin
            {s.scl, s.sda, s.drive} = 3'b111;
            if (i_cmd == i2cm_pkg::CMD_WRITE || i_cmd == i2cm_pkg::CMD_READ) begin
                s.req.dev_addr     = i_dev_addr;
                s.req.reg_addr     = i_reg_addr;
                s.req.write_data   = i_write_data;
                s.req.use_reg_addr = i_use_reg_addr;
                s.req.is_read      = (i_cmd == i2cm_pkg::CMD_READ);
                s.attempt_count    = 4'd0;
                s = f_begin(s);
            end
        end

        // tick of the current phase
        unique case (s.phase)
            i2cm_pkg::PH_IDLE: ;
            i2cm_pkg::PH_W_START, i2cm_pkg::PH_R_START1, i2cm_pkg::PH_R_START2: begin
                if (s.wait_cnt == 8'd0) begin
                    {s.scl, s.sda, s.drive} = 3'b111;
                    s.wait_cnt = 8'd1;
                end else if (s.wait_cnt == 8'd1) begin
                    {s.scl, s.sda, s.drive} = 3'b101;
                    s.wait_cnt = 8'd2;
                end else begin
                    {s.scl, s.sda, s.drive} = 3'b001;
                    fin = 1'b1;
                end
            end
            i2cm_pkg::PH_W_DEV, i2cm_pkg::PH_W_REG, i2cm_pkg::PH_W_DATA,
            i2cm_pkg::PH_R_DEV, i2cm_pkg::PH_R_REG, i2cm_pkg::PH_R_DEVR: begin
                if (s.wait_cnt == 8'd0) begin
                    {s.scl, s.sda, s.drive} = {1'b0, s.shift_byte[7], 1'b1};
                    s.wait_cnt = 8'd1;
                end else begin
                    // data held from the low half, clock goes high
                    s.scl        = 1'b1;
                    s.drive      = 1'b1;
                    s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    s.wait_cnt   = 8'd0;
                    s.bit_count  = s.bit_count + 3'd1;
                    fin          = (s.bit_count == 3'd0);
                end
            end
            i2cm_pkg::PH_R_RECV: begin
                if (s.wait_cnt == 8'd0) begin
                    {s.scl, s.sda, s.drive} = 3'b010;
                    s.wait_cnt = s.wait_cnt + 8'd1;
                end else if (s.wait_cnt[0]) begin
                    {s.scl, s.sda, s.drive} = 3'b110;
                    s.shift_byte = {s.shift_byte[6:0], i_sda_in};
                    s.wait_cnt   = s.wait_cnt + 8'd1;
                end else begin
                    {s.scl, s.sda, s.drive} = 3'b010;
                    if (s.wait_cnt >= i2cm_pkg::RECV_LAST_TICK) begin
                        fin = 1'b1;
                    end else begin
                        s.wait_cnt = s.wait_cnt + 8'd1;
                    end
                end
            end
            i2cm_pkg::PH_R_NACK: begin
                if (s.wait_cnt == 8'd0) begin
                    {s.scl, s.sda, s.drive} = 3'b011;
                    s.wait_cnt = 8'd1;
                end else if (s.wait_cnt == 8'd1) begin
                    {s.scl, s.sda, s.drive} = 3'b111;
                    s.wait_cnt = 8'd2;
                end else begin
                    {s.scl, s.sda, s.drive} = 3'b011;
                    fin = 1'b1;
                end
            end
            i2cm_pkg::PH_STOP: begin
                if (s.wait_cnt == 8'd0) begin
                    {s.scl, s.sda, s.drive} = 3'b001;
                    s.wait_cnt = 8'd1;
                end else if (s.wait_cnt == 8'd1) begin
                    {s.scl, s.sda, s.drive} = 3'b101;
                    s.wait_cnt = 8'd2;
                end else begin
                    {s.scl, s.sda, s.drive} = 3'b111;
                    fin = 1'b1;
                end
            end
            default: begin
                // acknowledge wait: release, sample with SCL high, then SCL low
                if (s.bit_count == 3'd0) begin
                    {s.scl, s.sda, s.drive} = 3'b010;
                    s.bit_count = 3'd1;
                    s.wait_cnt  = 8'd0;
                end else if (s.bit_count == 3'd1) begin
                    {s.scl, s.sda, s.drive} = 3'b110;
                    if (!i_sda_in) begin
                        s.bit_count = 3'd2;
                    end else begin
                        s.wait_cnt = s.wait_cnt + 8'd1;
                        if (s.wait_cnt == i_cfg.ack_timeout) begin
                            s.ack_all   = 1'b0;
                            s.bit_count = 3'd2;
                        end
                    end
                end else begin
                    {s.scl, s.sda, s.drive} = 3'b011;
                    fin = 1'b1;
                end
            end
        endcase

        if (fin) begin
            unique case (s.phase)
                i2cm_pkg::PH_W_START:    s = f_enter(s, i2cm_pkg::PH_W_DEV);
                i2cm_pkg::PH_W_DEV:      s = f_enter(s, i2cm_pkg::PH_W_DEV_ACK);
                i2cm_pkg::PH_W_DEV_ACK:  s = f_enter(s, s.req.use_reg_addr ?
                                                     i2cm_pkg::PH_W_REG : i2cm_pkg::PH_W_DATA);
                i2cm_pkg::PH_W_REG:      s = f_enter(s, i2cm_pkg::PH_W_REG_ACK);
                i2cm_pkg::PH_W_REG_ACK:  s = f_enter(s, i2cm_pkg::PH_W_DATA);
                i2cm_pkg::PH_W_DATA:     s = f_enter(s, i2cm_pkg::PH_W_DATA_ACK);
                i2cm_pkg::PH_W_DATA_ACK: s = f_enter(s, i2cm_pkg::PH_STOP);
                i2cm_pkg::PH_R_START1:   s = f_enter(s, i2cm_pkg::PH_R_DEV);
                i2cm_pkg::PH_R_DEV:      s = f_enter(s, i2cm_pkg::PH_R_DEV_ACK);
                i2cm_pkg::PH_R_DEV_ACK:  s = f_enter(s, i2cm_pkg::PH_R_REG);
                i2cm_pkg::PH_R_REG:      s = f_enter(s, i2cm_pkg::PH_R_REG_ACK);
                i2cm_pkg::PH_R_REG_ACK:  s = f_enter(s, i2cm_pkg::PH_R_START2);
                i2cm_pkg::PH_R_START2:   s = f_enter(s, i2cm_pkg::PH_R_DEVR);
                i2cm_pkg::PH_R_DEVR:     s = f_enter(s, i2cm_pkg::PH_R_DEVR_ACK);
                i2cm_pkg::PH_R_DEVR_ACK: s = f_enter(s, i2cm_pkg::PH_R_RECV);
                i2cm_pkg::PH_R_RECV:     s = f_enter(s, i2cm_pkg::PH_R_NACK);
                i2cm_pkg::PH_R_NACK:     s = f_enter(s, i2cm_pkg::PH_STOP);
                default: begin
                    // end of STOP: finish, or retry the whole attempt
                    if (s.ack_all) begin
                        done    = 1'b1;
                        ok      = 1'b1;
                        rd      = s.req.is_read ? s.shift_byte : 8'd0;
                        s.phase = i2cm_pkg::PH_IDLE;
                    end else begin
                        att             = s.attempt_count + 4'd1;
                        s.attempt_count = att;
                        if (att >= i_cfg.retry_limit) begin
                            done    = 1'b1;
                            s.phase = i2cm_pkg::PH_IDLE;
                        end else begin
                            s = f_begin(s);
                        end
                    end
                end
            endcase
        end

        o_state            = s;
        o_result.scl_level = s.scl;
        o_result.sda_level = s.sda;
        o_result.sda_drive = s.drive;
        o_result.busy_res  = (s.phase != i2cm_pkg::PH_IDLE);
        o_result.done_res  = done;
        o_result.ack_ok    = ok;
        o_result.read_data = rd;
    end

endmodule

// ===== design/i2c_master_byte_transfer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_transfer
// I2C master engine for single-byte register writes and reads, one bus tick
// per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one bus timing tick carrying the sampled SDA
//   level and, while the engine is idle, an optional write or read request.
//   Each input transaction yields exactly one output transaction with the
//   line levels to drive, busy, and done/ack_ok/read_data on the final tick.
//   The engine state register and the output register are both loaded at the
//   accepting edge, so the result appears in the cycle after acceptance and a
//   new tick is accepted every cycle while the output is not stalled.
//   When the receiver stalls, the output register holds its result and
//   o_ready drops until it is taken; ticks are never lost or repeated.
//   Configuration (retry limit, ack timeout) goes through the plain write
//   port; the user must write it only while no transfer is in flight.
//   The block does not enforce this. Reset (synchronous, active low) returns
//   the engine to idle with both lines driven high, empties the output
//   register and reloads the default retry limit of 5 and ack timeout of 255.
// ----------------------------------------------------------------------------
module i2c_master_byte_transfer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_dev_addr,
    input  logic [7:0] i_reg_addr,
    input  logic       i_use_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ack_ok,
    output logic [7:0] o_read_data
);

    i2cm_pkg::t_eng_state r_state;
    i2cm_pkg::t_eng_state n_state;
    i2cm_pkg::t_cfg       r_cfg;
    i2cm_pkg::t_result    r_result;
    i2cm_pkg::t_result    n_result;
    logic                 r_out_valid;
    logic                 in_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    i2cm_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_cmd          (i_cmd),
        .i_dev_addr     (i_dev_addr),
        .i_reg_addr     (i_reg_addr),
        .i_use_reg_addr (i_use_reg_addr),
        .i_write_data   (i_write_data),
        .i_sda_in       (i_sda_in),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit <= i2cm_pkg::RETRY_LIMIT_RST;
            r_cfg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                i2cm_pkg::CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_data[3:0];
                i2cm_pkg::CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cm_pkg::ENG_STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_result.scl_level;
    assign o_sda_level = r_result.sda_level;
    assign o_sda_drive = r_result.sda_drive;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_ack_ok    = r_result.ack_ok;
    assign o_read_data = r_result.read_data;

    // done always ends the transaction
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ack_ok |-> o_done_res)
        else $error("ack_ok outside a done tick");

    a_data_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_data != 8'd0) |-> o_done_res && o_ack_ok)
        else $error("read data reported without a successful read");

    // bus idles with both lines driven high
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_scl_level && o_sda_level && o_sda_drive)
        else $error("bus not released high while idle");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_state))
        else $error("engine state moved without an input transaction");

endmodule
